[sv/dtj_pkg.sv]
// shared types and constants for the disparity to jet color pipeline
package dtj_pkg;

	localparam int BYTE_W     = 8;
	localparam int DISP_W     = 16;
	localparam int SCALE_W    = 24;
	localparam int MIN_W      = 16;
	localparam int RANGE_W    = 17;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	// 23 * range and 46 * range for ranges up to 17 bits
	localparam int DEN_W  = 22;
	localparam int DSOR_W = DEN_W + 1;

	// scale * disparity, and that minus the shifted offset
	// (min << frac fits in PROD_W bits for up to 24 fraction bits)
	localparam int PROD_W = SCALE_W + DISP_W;
	localparam int NUM_W  = PROD_W + 1;

	// 40 * num + den, signed, and its magnitude
	localparam int NSUM_W = NUM_W + 6;
	localparam int MAG_W  = NSUM_W - 1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE  = 2'd0,
		REG_MIN    = 2'd1,
		REG_RANGE  = 2'd2,
		REG_ENDIAN = 2'd3
	} cfg_reg_t;

	// configuration as seen by the pipeline
	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [MIN_W-1:0]   min_disp;
		logic [DEN_W-1:0]   den;
		logic [DSOR_W-1:0]  dsor;
		logic               big_endian;
	} cfg_t;

	// front end to divider
	typedef struct packed {
		logic             zero;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} div_in_t;

	// divider status that travels with the quotient
	typedef struct packed {
		logic zero;
		logic neg;
		logic ovf;
		logic rnz;
	} div_flags_t;

endpackage

[sv/dtj_pix_if.sv]
// handshake channel carrying one raw disparity pixel as two bytes
interface dtj_pix_if;
	import dtj_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] first_byte;
	logic [BYTE_W-1:0] second_byte;

	modport source (output valid, output first_byte, output second_byte, input ready);
	modport sink (input valid, input first_byte, input second_byte, output ready);
endinterface

[sv/dtj_rgb_if.sv]
// handshake channel carrying one rgb888 pixel
interface dtj_rgb_if;
	import dtj_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] red;
	logic [BYTE_W-1:0] green;
	logic [BYTE_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[sv/dtj_front.sv]
// front end: byte assembly, scaling, offset and dividend forming in four stages
module dtj_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  dtj_pkg::cfg_t    cfg,
	dtj_pix_if.sink          pix,
	output logic             vld,
	output dtj_pkg::div_in_t dout
);
	import dtj_pkg::*;

	logic [DISP_W-1:0]        disp_x;
	logic [NUM_W-1:0]         min_sh_x;
	logic signed [NSUM_W-1:0] num_x;
	logic signed [NSUM_W-1:0] den_x;
	logic signed [NSUM_W-1:0] mag_x;

	logic [3:0]               v_s;
	logic                     zero_s1, zero_s2, zero_s3;
	logic [PROD_W-1:0]        prod_s1;
	logic signed [NUM_W-1:0]  num_s2;
	logic signed [NSUM_W-1:0] nsum_s3;

	assign pix.ready = adv;

	// byte order and operand forming
	always_comb begin
		disp_x   = cfg.big_endian ? {pix.first_byte, pix.second_byte}
		                          : {pix.second_byte, pix.first_byte};
		min_sh_x = NUM_W'(cfg.min_disp) << FRAC_BITS;
		num_x    = NSUM_W'(num_s2);
		den_x    = NSUM_W'({1'b0, cfg.den});
		mag_x    = nsum_s3[NSUM_W-1] ? -nsum_s3 : nsum_s3;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[2:0], pix.valid};
		end
	end

	// stage 1 scale, stage 2 offset, stage 3 times 40 plus rounding term, stage 4 magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1   <= (disp_x == '0);
			prod_s1   <= PROD_W'(cfg.scale) * PROD_W'(disp_x);
			zero_s2   <= zero_s1;
			num_s2    <= $signed({1'b0, prod_s1}) - $signed(min_sh_x);
			zero_s3   <= zero_s2;
			nsum_s3   <= (num_x <<< 5) + (num_x <<< 3) + den_x;
			dout.zero <= zero_s3;
			dout.neg  <= nsum_s3[NSUM_W-1];
			dout.mag  <= mag_x[MAG_W-1:0];
		end
	end

	assign vld = v_s[3];

endmodule

[sv/dtj_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow check
module dtj_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  dtj_pkg::cfg_t        cfg,
	input  logic                 vld_in,
	input  dtj_pkg::div_in_t     din,
	output logic                 vld,
	output dtj_pkg::div_flags_t  flags,
	output logic [FRAC_BITS+2:0] qm
);
	import dtj_pkg::*;

	localparam int QW = FRAC_BITS + 3;
	localparam int RW = DSOR_W + QW;
	localparam int CW = (MAG_W > RW) ? MAG_W : RW;

	logic [CW-1:0] mag_x;
	logic [CW-1:0] lim_x;
	logic [RW:0]   diff [QW];

	logic [QW:0]   v_s;
	logic [RW-1:0] rem_s [QW+1];
	logic [QW-1:0] qm_s [QW+1];
	div_flags_t    fl_s [QW+1];

	// overflow limit and trial subtractions of every stage
	always_comb begin
		mag_x = CW'(din.mag);
		lim_x = CW'(cfg.dsor) << QW;
		for (int k = 0; k < QW; k++) begin
			diff[k] = {1'b0, rem_s[k]} - ({1'b0, RW'(cfg.dsor)} << (QW - 1 - k));
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[QW-1:0], vld_in};
		end
	end

	// stage 0 checks the quotient fits, later stages each settle one bit
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= mag_x[RW-1:0];
			qm_s[0]  <= '0;
			fl_s[0]  <= '{zero: din.zero, neg: din.neg, ovf: (mag_x >= lim_x), rnz: 1'b0};
			for (int k = 0; k < QW; k++) begin
				rem_s[k+1] <= diff[k][RW] ? rem_s[k] : diff[k][RW-1:0];
				qm_s[k+1]  <= {qm_s[k][QW-2:0], ~diff[k][RW]};
				fl_s[k+1]  <= fl_s[k];
			end
		end
	end

	assign vld   = v_s[QW];
	assign qm    = qm_s[QW];
	assign flags = '{zero: fl_s[QW].zero, neg: fl_s[QW].neg, ovf: fl_s[QW].ovf,
	                 rnz: |rem_s[QW]};

endmodule

[sv/dtj_color.sv]
// quotient to jet color: offset and saturate, tent per channel, scale, output skid
module dtj_color #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	output logic                 adv,
	input  logic                 vld_in,
	input  dtj_pkg::div_flags_t  flags,
	input  logic [FRAC_BITS+2:0] qm,
	dtj_rgb_if.source            rgb
);
	import dtj_pkg::*;

	localparam int QW   = FRAC_BITS + 3;
	localparam int XW   = QW + 2;
	localparam int VW   = FRAC_BITS + 3;
	localparam int AW   = VW + 4;
	localparam int TW   = FRAC_BITS + 1;
	localparam int PW   = TW + 8;
	localparam int ONE  = 1 << FRAC_BITS;
	localparam int QTR  = ONE / 4;
	localparam int HALF = ONE / 2;
	localparam int TENT = 3 * ONE / 2;
	localparam int OFF  = (ONE + 5) / 10;
	localparam logic signed [XW-1:0] V_HI = XW'(4 * ONE - 1);
	localparam logic signed [XW-1:0] V_LO = XW'(-4 * ONE);

	logic signed [XW-1:0]     q_x;
	logic signed [XW-1:0]     v_x;
	logic signed [XW-1:0]     vsat_x;
	logic signed [AW-1:0]     a_x [3];
	logic signed [AW-1:0]     t_x [3];
	logic [TW-1:0]            tc_x [3];
	logic [PW-1:0]            p_x [3];
	logic [2:0][BYTE_W-1:0]   ch_x;
	logic                     push;

	logic                     v_s1, v_s2;
	logic                     zero_s1, zero_s2;
	logic signed [VW-1:0]     v_val_s1;
	logic [TW-1:0]            t_s2 [3];

	logic                     out_vld_q;
	logic                     skid_vld_q;
	logic [2:0][BYTE_W-1:0]   out_ch_q;
	logic [2:0][BYTE_W-1:0]   skid_ch_q;

	// the pipeline moves while the skid entry is free
	assign adv  = !skid_vld_q;
	assign push = adv && v_s2;

	// signed quotient with floor rounding, plus the 0.1 offset, then saturation
	always_comb begin
		q_x = flags.neg ? (~{2'b00, qm} + {{(XW-1){1'b0}}, ~flags.rnz}) : {2'b00, qm};
		v_x = q_x + XW'(OFF);
		if (flags.ovf) begin
			vsat_x = flags.neg ? V_LO : V_HI;
		end else if (v_x > V_HI) begin
			vsat_x = V_HI;
		end else if (v_x < V_LO) begin
			vsat_x = V_LO;
		end else begin
			vsat_x = v_x;
		end
	end

	// tent 1.5 - 4|v - c| clamped to [0, 1]; red, green, blue centers 3/4, 1/2, 1/4
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_x[i] = AW'(v_val_s1) - AW'((3 - i) * QTR);
			t_x[i] = a_x[i][AW-1] ? (AW'(TENT) + (a_x[i] <<< 2))
			                      : (AW'(TENT) - (a_x[i] <<< 2));
			if (t_x[i] < 0) begin
				tc_x[i] = '0;
			end else if (t_x[i] > AW'(ONE)) begin
				tc_x[i] = TW'(ONE);
			end else begin
				tc_x[i] = t_x[i][TW-1:0];
			end
		end
	end

	// 255 * t rounded back to a byte, black for a zero disparity
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_x[i]  = ({t_s2[i], 8'b0} - PW'(t_s2[i])) + PW'(HALF);
			ch_x[i] = zero_s2 ? '0 : p_x[i][FRAC_BITS+7:FRAC_BITS];
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1  <= flags.zero;
			v_val_s1 <= vsat_x[VW-1:0];
			zero_s2  <= zero_s1;
			t_s2     <= tc_x;
		end
	end

	// output word and skid entry control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (rgb.ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !rgb.ready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (rgb.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output word and skid entry data
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (rgb.ready) begin
				out_ch_q <= skid_ch_q;
			end
		end else if (push) begin
			if (out_vld_q && !rgb.ready) begin
				skid_ch_q <= ch_x;
			end else begin
				out_ch_q <= ch_x;
			end
		end
	end

	assign rgb.valid = out_vld_q;
	assign rgb.red   = out_ch_q[0];
	assign rgb.green = out_ch_q[1];
	assign rgb.blue  = out_ch_q[2];

`ifndef ASSERT_OFF
	// a word waits in the skid entry only behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry holds a word while the output is empty");

	// the skid entry fills only when the output word was stalled
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !$past(skid_vld_q) |-> $past(out_vld_q && !rgb.ready))
		else $error("skid entry filled without an output stall");

	// a word leaving the pipeline into a stalled output is kept in the skid entry
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_vld_q && !rgb.ready |=> skid_vld_q)
		else $error("word dropped at a stalled output");

	// a frozen pipeline keeps its valid bits
	a_frozen_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s2))
		else $error("pipeline moved while frozen");
`endif

endmodule

[sv/disparity_to_jet_color.sv]
// Disparity to jet color converter, top level.
//
// Channel pix takes one 16-bit disparity word per handshake as two raw bytes;
// the big_endian register selects which byte is high. Channel rgb returns one
// rgb888 word per accepted pixel, in order. A zero disparity comes out black.
// Registers are written through cfg_we / cfg_index / cfg_data while no pixel
// is in flight: 0 scale (unsigned, FRAC_BITS fraction bits), 1 min disparity,
// 2 disparity range (0 is taken as 1), 3 byte order.
//
// Throughput is one pixel per clock while the skid entry is free. From accept
// to rgb.valid a pixel passes a four-stage front end, the divider (an overflow
// check stage, then FRAC_BITS + 3 stages that each settle one quotient bit),
// two color stages and the output register.
//
// Reset clears every valid bit and loads the register defaults (scale 4096,
// min 0, range 256, little endian). When rgb stalls, one more word goes to a
// skid entry behind the output register; with that entry full the whole
// pipeline freezes and pix.ready stays low until rgb takes a word.
module disparity_to_jet_color #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	dtj_pix_if.sink                            pix,
	dtj_rgb_if.source                          rgb,
	input  logic                               cfg_we,
	input  logic [dtj_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtj_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dtj_pkg::*;

	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(4096);
	localparam logic [MIN_W-1:0]   MIN_RST   = '0;
	localparam logic [RANGE_W-1:0] RANGE_RST = RANGE_W'(256);

	// 23 * range, a zero range counts as one
	function automatic logic [DEN_W-1:0] den_of(input logic [RANGE_W-1:0] r);
		logic [DEN_W-1:0] rx;
		rx = (r == '0) ? DEN_W'(1) : DEN_W'(r);
		return (rx << 4) + (rx << 2) + (rx << 1) + rx;
	endfunction

	logic [SCALE_W-1:0]   scale_q;
	logic [MIN_W-1:0]     min_q;
	logic [DEN_W-1:0]     den_q;
	logic                 endian_q;

	cfg_t                 cfg;
	logic                 adv;
	logic                 front_vld;
	div_in_t              front_out;
	logic                 div_vld;
	div_flags_t           div_flags;
	logic [FRAC_BITS+2:0] div_qm;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RST;
			min_q    <= MIN_RST;
			den_q    <= den_of(RANGE_RST);
			endian_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				REG_MIN:    min_q    <= cfg_data[MIN_W-1:0];
				REG_RANGE:  den_q    <= den_of(cfg_data[RANGE_W-1:0]);
				REG_ENDIAN: endian_q <= cfg_data[0];
			endcase
		end
	end

	assign cfg = '{scale: scale_q, min_disp: min_q, den: den_q, dsor: {den_q, 1'b0},
	               big_endian: endian_q};

	// front end
	dtj_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg),
		.pix    (pix),
		.vld    (front_vld),
		.dout   (front_out)
	);

	// divider
	dtj_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg),
		.vld_in (front_vld),
		.din    (front_out),
		.vld    (div_vld),
		.flags  (div_flags),
		.qm     (div_qm)
	);

	// color mapping and output
	dtj_color #(
		.FRAC_BITS(FRAC_BITS)
	) u_color (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_in (div_vld),
		.flags  (div_flags),
		.qm     (div_qm),
		.rgb    (rgb)
	);

endmodule
